/* rtl/hpc_pkg.sv */
// Shared types and constants for the HV precharge controller with tilt filter.
// No dependencies; imported by every module of the block.
package hpc_pkg;

  localparam int ANGLE_W    = 32;
  localparam int VAR_W      = 31;
  localparam int OP_A_W     = 33;
  localparam int VOLT_W     = 16;
  localparam int TEMP_W     = 9;
  localparam int TILT_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int S_TDATA_W  = 184;
  localparam int M_TDATA_W  = 136;

  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_OFS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_OFS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PACK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CTEMP_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MTEMP_LIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_LIM   = 3'd5;

  typedef enum logic [1:0] {
    HV_OFF       = 2'd0,
    HV_PRECHARGE = 2'd1,
    HV_ON        = 2'd2,
    HV_FAULT     = 2'd3
  } hv_mode_e;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_PRED_MUL,
    SEQ_PRED_ADD,
    SEQ_DIV,
    SEQ_GAIN_MUL,
    SEQ_GAIN_ADD,
    SEQ_VAR_MUL,
    SEQ_VAR_ADD,
    SEQ_DONE
  } seq_state_e;

endpackage

/* rtl/hpc_mac.sv */
// Shared multiply / round / accumulate unit: res = sat32(c + round(a*b / 2^F)).
// Product is registered; rounding, add and saturation follow next cycle. Uses hpc_pkg.
module hpc_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                mul_en_i,
  input  logic signed [hpc_pkg::OP_A_W-1:0]   a_i,
  input  logic signed [FRAC_BITS+1:0]         b_i,
  input  logic signed [hpc_pkg::ANGLE_W-1:0]  c_i,
  output logic signed [hpc_pkg::ANGLE_W-1:0]  res_o
);
  import hpc_pkg::*;

  localparam int PW = OP_A_W + FRAC_BITS + 2;
  localparam int SW = PW + 1;
  localparam logic signed [PW-1:0] Half = PW'(1) << (FRAC_BITS - 1);

  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] rnd;
  logic signed [SW-1:0] sum;
  logic [SW-ANGLE_W:0]  top_bits;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= PW'(a_i) * PW'(b_i);
    end
  end

  assign rnd      = (prod_q + Half) >>> FRAC_BITS;
  assign sum      = SW'(rnd) + SW'(c_i);
  assign top_bits = sum[SW-1:ANGLE_W-1];

  always_comb begin
    if (top_bits != '0 && top_bits != '1) begin
      res_o = sum[SW-1] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
    end else begin
      res_o = sum[ANGLE_W-1:0];
    end
  end

endmodule

/* rtl/hpc_div.sv */
// Iterative restoring divider for the Kalman gain k = round(p*2^F / (p + 9*2^F)).
// One quotient bit per cycle, FRAC_BITS+1 quotient bits. Uses hpc_pkg.
module hpc_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [hpc_pkg::VAR_W-1:0]        p_i,
  output logic                             busy_o,
  output logic [FRAC_BITS:0]               k_o
);
  import hpc_pkg::*;

  localparam int QW = FRAC_BITS + 1;
  localparam int NW = VAR_W + FRAC_BITS + 1;
  localparam int DW = ANGLE_W;
  localparam int CW = $clog2(QW + 1);
  localparam logic [DW-1:0] MeasVar = DW'(64'd9 << FRAC_BITS);

  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [QW-1:0] lo_q;
  logic [DW-1:0] den;
  logic [NW-1:0] num;
  logic [DW:0]   trial;
  logic          ge;

  assign den   = DW'(p_i) + MeasVar;
  assign num   = (NW'(p_i) << FRAC_BITS) + NW'(den >> 1);
  assign trial = {rem_q, lo_q[QW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(QW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den;
      rem_q <= DW'(num[NW-1:QW]);
      lo_q  <= num[QW-1:0];
    end else if (cnt_q != '0) begin
      rem_q <= ge ? DW'(trial - {1'b0, den_q}) : DW'(trial);
      lo_q  <= {lo_q[QW-2:0], ge};
    end
  end

  assign busy_o = cnt_q != '0;
  assign k_o    = lo_q;

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> rem_q < den_q)
    else $error("divider remainder not below divisor");

  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_o && $past(busy_o)) |-> k_o <= (QW'(1) << FRAC_BITS))
    else $error("gain above one");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o)
    else $error("divider restarted while busy");

endmodule

/* rtl/hv_precharge_controller_with_tilt_filter_top.sv */
// Top level: HV contactor state machine, per-axis Kalman tilt filter sequencer.
// Instantiates hpc_mac and hpc_div; uses hpc_pkg.
//
//  channel  dir  handshake                      content
//  s_axis   in   s_axis_tvalid/s_axis_tready    one control tick
//  m_axis   out  m_axis_tvalid/m_axis_tready    drives, new HV mode, estimates
//  cfg      in   cfg_we_i                       register index and data
//
// Each tick runs, per axis, the divider and six MAC steps (predict multiply and
// add, gain multiply and add, variance multiply and add); it then loads the
// output register and returns to idle before the next tick can be accepted.
// s_axis_tready is high only while the sequencer is idle; a finished item waits
// in the output register, and the next tick may be accepted meanwhile. While
// that register is still full, the next finished item holds the sequencer.
// Reset (rst_ni low, async) gives HV off, zero angles, variance 4.0, default config.
module hv_precharge_controller_with_tilt_filter_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hpc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hpc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // hv_switch_on, cells_ready, pack_voltage, controller_voltage, controller_temp,
  // motor_temp, roll_rate, pitch_rate, roll_measured, pitch_measured, zero pad
  input  logic [hpc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // hv_mode, contactor_closed, precharge_closed, roll_angle, pitch_angle,
  // roll_variance, pitch_variance, zero pad
  output logic [hpc_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
  import hpc_pkg::*;

  localparam int BW = FRAC_BITS + 2;
  localparam logic signed [BW-1:0] DtQ   = BW'(((64'd4 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [VAR_W-1:0] ProcQ =
    VAR_W'(((64'd256 << FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam logic [BW-1:0]    OneQ     = BW'(64'd1 << FRAC_BITS);
  localparam logic [VAR_W-1:0] UncReset = VAR_W'(64'd4 << FRAC_BITS);

  // input fields
  logic                      in_sw, in_cells;
  logic [VOLT_W-1:0]         in_pack, in_ctrl;
  logic signed [TEMP_W-1:0]  in_ctemp, in_mtemp;
  logic signed [ANGLE_W-1:0] in_rrate, in_prate, in_rmeas, in_pmeas;

  assign in_sw    = s_axis_tdata[0];
  assign in_cells = s_axis_tdata[1];
  assign in_pack  = s_axis_tdata[17:2];
  assign in_ctrl  = s_axis_tdata[33:18];
  assign in_ctemp = s_axis_tdata[42:34];
  assign in_mtemp = s_axis_tdata[51:43];
  assign in_rrate = s_axis_tdata[83:52];
  assign in_prate = s_axis_tdata[115:84];
  assign in_rmeas = s_axis_tdata[147:116];
  assign in_pmeas = s_axis_tdata[179:148];

  // config
  logic signed [ANGLE_W-1:0] roll_ofs_q, pitch_ofs_q;
  logic [VOLT_W-1:0]         min_pack_q;
  logic signed [TEMP_W-1:0]  ctemp_lim_q, mtemp_lim_q;
  logic [TILT_W-1:0]         tilt_lim_q;

  // state
  seq_state_e                state_q, state_d;
  hv_mode_e                  phase_q, phase_d;
  logic                      axis_q, axis_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [ANGLE_W-1:0] roll_est_q, pitch_est_q;
  logic [VAR_W-1:0]          roll_unc_q, pitch_unc_q;

  // item
  logic signed [OP_A_W-1:0]  roll_rate_q, pitch_rate_q;
  logic signed [ANGLE_W-1:0] roll_meas_q, pitch_meas_q;
  logic signed [ANGLE_W-1:0] pred_q;
  logic [VAR_W-1:0]          p_q;
  hv_mode_e                  mode_q;
  logic                      con_q, pre_q;

  // output register
  hv_mode_e                  out_mode_q;
  logic                      out_con_q, out_pre_q;
  logic signed [ANGLE_W-1:0] out_roll_q, out_pitch_q;
  logic [VAR_W-1:0]          out_rvar_q, out_pvar_q;

  logic                      accept, out_load, est_we, unc_we;
  logic                      mul_en, div_start, div_busy;
  logic [FRAC_BITS:0]        div_k;
  logic signed [OP_A_W-1:0]  mac_a;
  logic signed [BW-1:0]      mac_b;
  logic signed [ANGLE_W-1:0] mac_c, mac_res;

  logic signed [ANGLE_W-1:0] cur_est, cur_meas;
  logic signed [OP_A_W-1:0]  cur_rate;
  logic [VAR_W-1:0]          cur_unc, p_cur;
  logic [VAR_W:0]            unc_sum;

  logic                      unsafe, charged, tilted;
  logic signed [VOLT_W:0]    vdiff;
  logic signed [VOLT_W+4:0]  vdiff10;
  logic signed [ANGLE_W:0]   lim_pos, lim_neg;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = state_q == SEQ_IDLE;

  assign cur_est  = axis_q ? pitch_est_q  : roll_est_q;
  assign cur_unc  = axis_q ? pitch_unc_q  : roll_unc_q;
  assign cur_rate = axis_q ? pitch_rate_q : roll_rate_q;
  assign cur_meas = axis_q ? pitch_meas_q : roll_meas_q;
  assign unc_sum  = {1'b0, cur_unc} + {1'b0, ProcQ};
  assign p_cur    = unc_sum[VAR_W] ? '1 : unc_sum[VAR_W-1:0];

  assign unsafe  = (in_ctemp >= ctemp_lim_q) || (in_mtemp >= mtemp_lim_q);
  assign vdiff   = $signed({1'b0, in_pack}) - $signed({1'b0, in_ctrl});
  assign vdiff10 = (VOLT_W+5)'(vdiff) * $signed((VOLT_W+5)'(10));
  assign charged = in_cells && (vdiff10 <= $signed({5'b0, in_pack})) && (in_pack > min_pack_q);
  assign lim_pos = $signed({9'b0, tilt_lim_q});
  assign lim_neg = -lim_pos;
  assign tilted  = ((ANGLE_W+1)'(roll_est_q) > lim_pos) || ((ANGLE_W+1)'(roll_est_q) < lim_neg)
                || ((ANGLE_W+1)'(pitch_est_q) > lim_pos) || ((ANGLE_W+1)'(pitch_est_q) < lim_neg);

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      case (phase_q)
        HV_OFF: begin
          if (in_sw) phase_d = HV_PRECHARGE;
        end
        HV_PRECHARGE: begin
          if (!in_sw) phase_d = HV_OFF;
          else if (unsafe) phase_d = HV_FAULT;
          else if (charged) phase_d = HV_ON;
        end
        HV_ON: begin
          if (!in_sw) phase_d = HV_OFF;
          else if (unsafe || tilted) phase_d = HV_FAULT;
        end
        default: begin
          if (!in_sw) phase_d = HV_OFF;
        end
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    mul_en    = 1'b0;
    div_start = 1'b0;
    est_we    = 1'b0;
    unc_we    = 1'b0;
    out_load  = 1'b0;
    mac_a     = '0;
    mac_b     = '0;
    mac_c     = '0;
    case (state_q)
      SEQ_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = SEQ_PRED_MUL;
          axis_d  = 1'b0;
        end
      end
      SEQ_PRED_MUL: begin
        mul_en    = 1'b1;
        mac_a     = cur_rate;
        mac_b     = DtQ;
        div_start = 1'b1;
        state_d   = SEQ_PRED_ADD;
      end
      SEQ_PRED_ADD: begin
        mac_c   = cur_est;
        state_d = SEQ_DIV;
      end
      SEQ_DIV: begin
        if (!div_busy) state_d = SEQ_GAIN_MUL;
      end
      SEQ_GAIN_MUL: begin
        mul_en  = 1'b1;
        mac_a   = OP_A_W'(cur_meas) - OP_A_W'(pred_q);
        mac_b   = BW'(div_k);
        state_d = SEQ_GAIN_ADD;
      end
      SEQ_GAIN_ADD: begin
        mac_c   = pred_q;
        est_we  = 1'b1;
        state_d = SEQ_VAR_MUL;
      end
      SEQ_VAR_MUL: begin
        mul_en  = 1'b1;
        mac_a   = OP_A_W'(p_q);
        mac_b   = OneQ - BW'(div_k);
        state_d = SEQ_VAR_ADD;
      end
      SEQ_VAR_ADD: begin
        unc_we = 1'b1;
        if (!axis_q) begin
          axis_d  = 1'b1;
          state_d = SEQ_PRED_MUL;
        end else begin
          state_d = SEQ_DONE;
        end
      end
      SEQ_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = SEQ_IDLE;
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tvalid && m_axis_tready) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      phase_q     <= HV_OFF;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
      roll_est_q  <= '0;
      pitch_est_q <= '0;
      roll_unc_q  <= UncReset;
      pitch_unc_q <= UncReset;
      roll_ofs_q  <= '0;
      pitch_ofs_q <= '0;
      min_pack_q  <= 16'd800;
      ctemp_lim_q <= 9'sd100;
      mtemp_lim_q <= 9'sd120;
      tilt_lim_q  <= 24'd2949120;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
      if (est_we) begin
        if (axis_q) pitch_est_q <= mac_res;
        else roll_est_q <= mac_res;
      end
      if (unc_we) begin
        if (axis_q) pitch_unc_q <= mac_res[VAR_W-1:0];
        else roll_unc_q <= mac_res[VAR_W-1:0];
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROLL_OFS:  roll_ofs_q  <= cfg_data_i;
          CFG_PITCH_OFS: pitch_ofs_q <= cfg_data_i;
          CFG_MIN_PACK:  min_pack_q  <= cfg_data_i[VOLT_W-1:0];
          CFG_CTEMP_LIM: ctemp_lim_q <= cfg_data_i[TEMP_W-1:0];
          CFG_MTEMP_LIM: mtemp_lim_q <= cfg_data_i[TEMP_W-1:0];
          CFG_TILT_LIM:  tilt_lim_q  <= cfg_data_i[TILT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      roll_rate_q  <= OP_A_W'(in_rrate) - OP_A_W'(roll_ofs_q);
      pitch_rate_q <= OP_A_W'(in_prate) - OP_A_W'(pitch_ofs_q);
      roll_meas_q  <= in_rmeas;
      pitch_meas_q <= in_pmeas;
      mode_q       <= phase_d;
      con_q        <= phase_q == HV_ON;
      pre_q        <= phase_q == HV_PRECHARGE;
    end
    if (state_q == SEQ_PRED_MUL) p_q <= p_cur;
    if (state_q == SEQ_PRED_ADD) pred_q <= mac_res;
    if (out_load) begin
      out_mode_q  <= mode_q;
      out_con_q   <= con_q;
      out_pre_q   <= pre_q;
      out_roll_q  <= roll_est_q;
      out_pitch_q <= pitch_est_q;
      out_rvar_q  <= roll_unc_q;
      out_pvar_q  <= pitch_unc_q;
    end
  end

  hpc_mac #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .mul_en_i (mul_en),
    .a_i      (mac_a),
    .b_i      (mac_b),
    .c_i      (mac_c),
    .res_o    (mac_res)
  );

  hpc_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .p_i     (p_cur),
    .busy_o  (div_busy),
    .k_o     (div_k)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_pvar_q, out_rvar_q, out_pitch_q, out_roll_q,
                          out_pre_q, out_con_q, out_mode_q};

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == SEQ_PRED_MUL) && !axis_q)
    else $error("accepted item did not start roll axis");

  a_gain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_GAIN_MUL || state_q == SEQ_VAR_MUL) |-> !div_busy)
    else $error("gain used while divider busy");

  a_var_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_VAR_ADD) |-> !mac_res[ANGLE_W-1])
    else $error("negative variance");

endmodule

/* sim/hv_precharge_controller_with_tilt_filter_top_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for hv_precharge_controller_with_tilt_filter_top: HV state
// machine and roll/pitch filter against a local bit-accurate predictor.
// Depends on hpc_pkg and the top-level RTL only.
module hv_precharge_controller_with_tilt_filter_top_test;
  import hpc_pkg::*;

  localparam int FRAC = 16;
  localparam longint ONE_Q = longint'(1) << FRAC;
  localparam longint DT_Q = (4 * ONE_Q + 500) / 1000;
  localparam longint PROC_Q = (256 * ONE_Q + 500000) / 1000000;
  localparam longint MEAS_VAR_Q = 9 * ONE_Q;
  localparam longint HALF_Q = ONE_Q / 2;
  localparam longint I32_MAX = 2147483647;
  localparam longint I32_MIN = -I32_MAX - 1;
  localparam longint VAR_MAX = I32_MAX;
  localparam logic [23:0] TILT_MAX = 24'd11796480;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam int SETTLE_CYC = 64;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [3:0]         pad;
    logic signed [31:0] pitch_meas;
    logic signed [31:0] roll_meas;
    logic signed [31:0] pitch_rate;
    logic signed [31:0] roll_rate;
    logic signed [8:0]  motor_temp;
    logic signed [8:0]  ctrl_temp;
    logic [15:0]        ctrl_volt;
    logic [15:0]        pack_volt;
    logic               cells_ready;
    logic               hv_switch;
  } tick_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic [30:0] pitch_var;
    logic [30:0] roll_var;
    logic [31:0] pitch_angle;
    logic [31:0] roll_angle;
    logic        precharge;
    logic        contactor;
    hv_mode_e    mode;
  } res_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;

  // predictor state and register mirror
  hv_mode_e           hv_q;
  longint             angle_q[2];
  longint             unc_q[2];
  logic signed [31:0] ofs_q[2];
  logic [15:0]        min_pack_q;
  logic signed [8:0]  ctemp_lim_q;
  logic signed [8:0]  mtemp_lim_q;
  logic [23:0]        tilt_lim_q;

  res_t expected_results[$];
  int   errors;
  int   quiet_cycles;
  bit   src_idle_en;
  bit   snk_stall_en;

  hv_precharge_controller_with_tilt_filter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint clamp32(longint x);
    if (x > I32_MAX) return I32_MAX;
    if (x < I32_MIN) return I32_MIN;
    return x;
  endfunction

  function automatic void filter_axis(int ax, longint rate, longint meas);
    longint pred, p, den, k;
    pred = clamp32(angle_q[ax] + ((DT_Q * rate + HALF_Q) >>> FRAC));
    p = unc_q[ax] + PROC_Q;
    if (p > VAR_MAX) p = VAR_MAX;
    den = p + MEAS_VAR_Q;
    k = (p * ONE_Q + den / 2) / den;
    angle_q[ax] = clamp32(pred + ((k * (meas - pred) + HALF_Q) >>> FRAC));
    unc_q[ax] = ((ONE_Q - k) * p + HALF_Q) >>> FRAC;
  endfunction

  function automatic res_t predict_tick(tick_t t);
    res_t     r;
    longint   pk, cv, ct, mt, clim, mlim, lim, rr, pr, rm, pm, ro, po;
    logic     unsafe, charged, tilted;
    hv_mode_e prev, nxt;
    pk = longint'(t.pack_volt);
    cv = longint'(t.ctrl_volt);
    ct = longint'(t.ctrl_temp);
    mt = longint'(t.motor_temp);
    clim = longint'(ctemp_lim_q);
    mlim = longint'(mtemp_lim_q);
    lim = longint'(tilt_lim_q);
    rr = longint'(t.roll_rate);
    pr = longint'(t.pitch_rate);
    rm = longint'(t.roll_meas);
    pm = longint'(t.pitch_meas);
    ro = longint'(ofs_q[0]);
    po = longint'(ofs_q[1]);
    unsafe = (ct >= clim) || (mt >= mlim);
    charged = t.cells_ready && (10 * (pk - cv) <= pk) && (pk > longint'(min_pack_q));
    tilted = angle_q[0] > lim || angle_q[0] < -lim || angle_q[1] > lim || angle_q[1] < -lim;
    prev = hv_q;
    nxt = prev;
    case (prev)
      HV_OFF: if (t.hv_switch) nxt = HV_PRECHARGE;
      HV_PRECHARGE: begin
        if (!t.hv_switch) nxt = HV_OFF;
        else if (unsafe) nxt = HV_FAULT;
        else if (charged) nxt = HV_ON;
      end
      HV_ON: begin
        if (!t.hv_switch) nxt = HV_OFF;
        else if (unsafe || tilted) nxt = HV_FAULT;
      end
      default: if (!t.hv_switch) nxt = HV_OFF;
    endcase
    hv_q = nxt;
    filter_axis(0, rr - ro, rm);
    filter_axis(1, pr - po, pm);
    r = '0;
    r.mode = nxt;
    r.contactor = (prev == HV_ON);
    r.precharge = (prev == HV_PRECHARGE);
    r.roll_angle = angle_q[0][31:0];
    r.pitch_angle = angle_q[1][31:0];
    r.roll_var = unc_q[0][30:0];
    r.pitch_var = unc_q[1][30:0];
    return r;
  endfunction

  task automatic cmp_field(input string fname, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, fname, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      got = res_t'(m_axis_tdata);
      if (expected_results.size() == 0) begin
        $display("%0t unexpected item: expected none actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        cmp_field("hv_mode", 32'(want.mode), 32'(got.mode));
        cmp_field("contactor_closed", 32'(want.contactor), 32'(got.contactor));
        cmp_field("precharge_closed", 32'(want.precharge), 32'(got.precharge));
        cmp_field("roll_angle", want.roll_angle, got.roll_angle);
        cmp_field("pitch_angle", want.pitch_angle, got.pitch_angle);
        cmp_field("roll_variance", 32'(want.roll_var), 32'(got.roll_var));
        cmp_field("pitch_variance", 32'(want.pitch_var), 32'(got.pitch_var));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL hv_precharge_controller_with_tilt_filter_top");
      $finish;
    end
  end

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && snk_stall_en && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_tick(input tick_t t);
    s_axis_tdata <= t;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    expected_results.push_back(predict_tick(t));
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // stop sending and let every pending item come back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_ROLL_OFS:  ofs_q[0] = val;
      CFG_PITCH_OFS: ofs_q[1] = val;
      CFG_MIN_PACK:  min_pack_q = val[15:0];
      CFG_CTEMP_LIM: ctemp_lim_q = val[8:0];
      CFG_MTEMP_LIM: mtemp_lim_q = val[8:0];
      CFG_TILT_LIM:  tilt_lim_q = val[23:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] ro, input logic [31:0] po, input logic [15:0] mp,
                           input int ct, input int mt, input logic [23:0] tl);
    logic [8:0] c9, m9;
    c9 = ct[8:0];
    m9 = mt[8:0];
    write_reg(CFG_ROLL_OFS, ro);
    write_reg(CFG_PITCH_OFS, po);
    write_reg(CFG_MIN_PACK, {16'd0, mp});
    write_reg(CFG_CTEMP_LIM, {23'd0, c9});
    write_reg(CFG_MTEMP_LIM, {23'd0, m9});
    write_reg(CFG_TILT_LIM, {8'd0, tl});
    // spare indexes must not touch anything
    write_reg(CFG_SPARE_A, $urandom);
    write_reg(CFG_SPARE_B, $urandom);
  endtask

  function automatic tick_t make_tick(int sw, int cells, int pack, int ctrl, int ct, int mt);
    tick_t t;
    t = '0;
    t.hv_switch = sw[0];
    t.cells_ready = cells[0];
    t.pack_volt = pack[15:0];
    t.ctrl_volt = ctrl[15:0];
    t.ctrl_temp = ct[8:0];
    t.motor_temp = mt[8:0];
    return t;
  endfunction

  function automatic logic signed [8:0] pick_temp(input int lim);
    int r, v;
    r = $urandom_range(0, 99);
    if (r < 2) v = lim;
    else if (r < 4 || lim <= -64) v = int'($urandom_range(0, 319)) - 64;
    else v = int'($urandom_range(0, lim + 63)) - 64;
    return v[8:0];
  endfunction

  function automatic tick_t seq_tick(int lean_r, int lean_p);
    tick_t       t;
    int          r, pk, v;
    int unsigned mp;
    t = '0;
    t.hv_switch = ($urandom_range(0, 99) >= 8);
    t.cells_ready = ($urandom_range(0, 99) >= 12);
    mp = 32'(min_pack_q);
    r = $urandom_range(0, 9);
    if (r < 8 && mp < 65535) v = $urandom_range(mp + 1, 65535);
    else if (r == 8) v = int'(mp) + int'($urandom_range(0, 2)) - 1;
    else v = $urandom_range(0, 65535);
    t.pack_volt = v[15:0];
    pk = int'(t.pack_volt);
    r = $urandom_range(0, 19);
    if (r < 12) v = pk - int'($urandom_range(0, pk / 10));
    else if (r < 15) v = pk - pk / 10 - 1;
    else if (r < 17) v = $urandom_range(pk, 65535);
    else v = $urandom_range(0, 65535);
    t.ctrl_volt = v[15:0];
    t.ctrl_temp = pick_temp(ctemp_lim_q);
    t.motor_temp = pick_temp(mtemp_lim_q);
    if ($urandom_range(0, 99) == 0) t.roll_rate = $urandom;
    else t.roll_rate = ofs_q[0] + (int'($urandom_range(0, 2097152)) - 1048576);
    if ($urandom_range(0, 99) == 0) t.pitch_rate = $urandom;
    else t.pitch_rate = ofs_q[1] + (int'($urandom_range(0, 2097152)) - 1048576);
    if ($urandom_range(0, 99) == 0) t.roll_meas = $urandom;
    else t.roll_meas = lean_r + int'($urandom_range(0, 655360)) - 327680;
    if ($urandom_range(0, 99) == 0) t.pitch_meas = $urandom;
    else t.pitch_meas = lean_p + int'($urandom_range(0, 655360)) - 327680;
    return t;
  endfunction

  task automatic run_block(input int n);
    int lean_r, lean_p;
    lean_r = (int'($urandom_range(0, 120)) - 60) * 65536;
    lean_p = (int'($urandom_range(0, 120)) - 60) * 65536;
    repeat (n) send_tick(seq_tick(lean_r, lean_p));
  endtask

  task automatic test_directed();
    tick_t t;
    send_tick(make_tick(0, 0, 0, 0, 0, 0));
    send_tick(make_tick(1, 0, 0, 0, 0, 0));
    send_tick(make_tick(1, 0, 1000, 900, 0, 0));      // cells not ready
    send_tick(make_tick(1, 1, 800, 800, 0, 0));       // pack equal to minimum
    send_tick(make_tick(1, 1, 1000, 899, 0, 0));      // gap one count too wide
    send_tick(make_tick(1, 1, 1000, 900, 0, 0));      // gap exactly at limit
    send_tick(make_tick(1, 1, 1000, 900, 99, 119));
    send_tick(make_tick(1, 1, 1000, 900, 100, 0));    // controller at limit
    send_tick(make_tick(1, 1, 1000, 900, -64, -64));
    send_tick(make_tick(0, 1, 1000, 900, 0, 0));
    send_tick(make_tick(1, 0, 0, 0, 0, 0));
    send_tick(make_tick(1, 1, 1000, 900, 0, 120));    // motor at limit in precharge
    send_tick(make_tick(0, 0, 0, 0, 255, 255));
    send_tick(make_tick(1, 0, 0, 0, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 0));
    send_tick(make_tick(1, 0, 0, 0, 0, 0));
    send_tick(make_tick(1, 1, 65535, 65535, 0, 0));
    send_tick(make_tick(1, 1, 0, 65535, 255, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 0));
    send_tick(make_tick(1, 0, 0, 0, 0, 0));
    send_tick(make_tick(1, 1, 801, 65535, 0, 0));     // controller above pack
    t = make_tick(1, 1, 801, 800, 0, 0);
    send_tick(t);
    send_tick(make_tick(0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_tilt();
    tick_t t;
    settle();
    write_reg(CFG_TILT_LIM, 32'd0);
    send_tick(make_tick(1, 0, 0, 0, 0, 0));
    send_tick(make_tick(1, 1, 1000, 900, 0, 0));
    send_tick(make_tick(1, 1, 1000, 900, 0, 0));      // estimate equal to limit
    t = make_tick(1, 1, 1000, 900, 0, 0);
    t.roll_meas = 32'sh0001_0000;
    send_tick(t);
    send_tick(make_tick(1, 1, 1000, 900, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 0));
    settle();
    write_reg(CFG_TILT_LIM, {8'd0, TILT_MAX});
    send_tick(make_tick(1, 0, 0, 0, 0, 0));
    send_tick(make_tick(1, 1, 1000, 900, 0, 0));
    t = make_tick(1, 1, 1000, 900, 0, 0);
    t.pitch_meas = 32'h8000_0000;
    send_tick(t);
    send_tick(make_tick(1, 1, 1000, 900, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_reg_extremes();
    settle();
    write_all(32'h8000_0000, 32'h7FFF_FFFF, 16'd0, -64, 255, 24'd0);
    run_block(40);
    settle();
    write_all(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 255, -64, TILT_MAX);
    run_block(40);
    settle();
    write_all(32'd0, 32'd0, 16'd800, 100, 120, 24'd2949120);
    run_block(40);
  endtask

  task automatic test_sequences(input int blocks);
    int ro, po;
    repeat (blocks) begin
      settle();
      ro = int'($urandom_range(0, 131072)) - 65536;
      po = int'($urandom_range(0, 131072)) - 65536;
      write_all(ro, po, 16'($urandom_range(0, 4000)), int'($urandom_range(60, 150)),
                int'($urandom_range(60, 150)), 24'($urandom_range(10, 90) << 16));
      src_idle_en = ($urandom_range(0, 9) < 7);
      snk_stall_en = ($urandom_range(0, 9) < 7);
      run_block(140);
    end
  endtask

  task automatic test_noise();
    tick_t t;
    repeat (150) begin
      t = '0;
      t.hv_switch = 1'($urandom);
      t.cells_ready = 1'($urandom);
      t.pack_volt = 16'($urandom);
      t.ctrl_volt = 16'($urandom);
      t.ctrl_temp = 9'(int'($urandom_range(0, 319)) - 64);
      t.motor_temp = 9'(int'($urandom_range(0, 319)) - 64);
      t.roll_rate = $urandom;
      t.pitch_rate = $urandom;
      t.roll_meas = $urandom;
      t.pitch_meas = $urandom;
      send_tick(t);
    end
  endtask

  function automatic logic [31:0] steer_rate(longint est);
    longint x;
    x = clamp32(-est * 250);
    return x[31:0];
  endfunction

  // drive both estimates into their clamps, then steer them back near zero
  task automatic test_saturation();
    tick_t t;
    int    n;
    settle();
    write_reg(CFG_ROLL_OFS, 32'h8000_0000);
    write_reg(CFG_PITCH_OFS, 32'h7FFF_FFFF);
    n = 0;
    while (n < 404) begin
      t = make_tick(0, 0, 0, 0, 0, 0);
      t.roll_rate = 32'h7FFF_FFFF;
      t.pitch_rate = 32'h8000_0000;
      t.roll_meas = 32'h7FFF_FFFF;
      t.pitch_meas = 32'h8000_0000;
      send_tick(t);
      n++;
      if (angle_q[0] == I32_MAX && angle_q[1] == I32_MIN && n < 400) n = 400;
    end
    settle();
    write_reg(CFG_ROLL_OFS, 32'd0);
    write_reg(CFG_PITCH_OFS, 32'd0);
    n = 0;
    while (n < 600 && (angle_q[0] > 1048576 || angle_q[0] < -1048576 ||
                       angle_q[1] > 1048576 || angle_q[1] < -1048576)) begin
      t = make_tick(0, 0, 0, 0, 0, 0);
      t.roll_rate = steer_rate(angle_q[0]);
      t.pitch_rate = steer_rate(angle_q[1]);
      send_tick(t);
      n++;
    end
  endtask

  task automatic test_final();
    settle();
    write_all(32'd0, 32'd0, 16'd800, 100, 120, 24'd2949120);
    src_idle_en = 1'b0;
    snk_stall_en = 1'b0;
    run_block(200);
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    src_idle_en = 1'b0;
    snk_stall_en = 1'b0;
    hv_q = HV_OFF;
    angle_q[0] = 0;
    angle_q[1] = 0;
    unc_q[0] = 4 * ONE_Q;
    unc_q[1] = 4 * ONE_Q;
    ofs_q[0] = 0;
    ofs_q[1] = 0;
    min_pack_q = 16'd800;
    ctemp_lim_q = 9'sd100;
    mtemp_lim_q = 9'sd120;
    tilt_lim_q = 24'd2949120;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    src_idle_en = 1'b1;
    snk_stall_en = 1'b1;
    test_tilt();
    test_reg_extremes();
    test_sequences(9);
    src_idle_en = 1'b1;
    snk_stall_en = 1'b1;
    test_noise();
    test_saturation();
    test_final();
    settle();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS hv_precharge_controller_with_tilt_filter_top");
    end else begin
      $display("FAIL hv_precharge_controller_with_tilt_filter_top");
    end
    $finish;
  end

endmodule
